FILE: hw/rtl/brdc_pkg.sv
// Package for the bit row dedup classifier.
// Sizes, transfer payload structs and the controller/datapath interface types.
// No dependencies.
package brdc_pkg;

	localparam int ROWS    = 128;
	localparam int COLS    = 64;
	localparam int IDX_W   = $clog2(ROWS);
	localparam int CNT_W   = $clog2(ROWS + 1);
	localparam int ID_W    = 7;
	localparam int VEC_W   = 64;
	localparam int TOTAL_W = 8;

	localparam logic [VEC_W-1:0] COL_MASK = {VEC_W{1'b1}} >> (VEC_W - COLS);

	typedef struct packed {
		logic [ID_W-1:0]  row_id;
		logic [VEC_W-1:0] row_bits;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]    class_rep;
		logic               is_new;
		logic [TOTAL_W-1:0] distinct_total;
	} result_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic commit_hit;
		logic commit_miss;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic exhausted;
	} status_t;

endpackage

FILE: hw/rtl/bit_row_dedup_classifier.sv
// Top level of the bit row dedup classifier.
// Joins brdc_ctrl and brdc_datapath. Depends on brdc_pkg.
//
// An item is taken when start is high and busy is low. Its row vector is
// compared with the stored distinct rows, oldest first, one table entry per
// cycle from a single-port memory read; the scan stops at the first match.
// A full table holds ROWS, 128 entries. The result is shown for exactly one
// cycle with done high and cannot be held off: the receiver must take it
// then. A new item may be started in the cycle the result is shown. When the
// table is full a miss returns the item's own id with is_new clear.
module bit_row_dedup_classifier (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  brdc_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output brdc_pkg::result_t result
);
	import brdc_pkg::*;

	cmd_t    cmd;
	status_t status;

	brdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	brdc_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result),
		.done   (done)
	);

endmodule

FILE: hw/rtl/brdc_ctrl.sv
// Controller for the bit row dedup classifier.
// Sequences load, table scan and commit. Depends on brdc_pkg.
module brdc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  brdc_pkg::status_t status,
	output brdc_pkg::cmd_t    cmd,
	output logic             busy
);
	import brdc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.hit) begin
					cmd.commit_hit = 1'b1;
					state_d        = ST_IDLE;
				end else if (status.exhausted) begin
					cmd.commit_miss = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/brdc_datapath.sv
// Datapath for the bit row dedup classifier.
// Row table memory, fill count, scan pointer, comparator and result register.
// Depends on brdc_pkg.
module brdc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  brdc_pkg::item_t   item,
	input  brdc_pkg::cmd_t    cmd,
	output brdc_pkg::status_t status,
	output brdc_pkg::result_t result,
	output logic              done
);
	import brdc_pkg::*;

	logic [ID_W+VEC_W-1:0] mem [ROWS];

	logic [ID_W-1:0]  id_q;
	logic [VEC_W-1:0] vec_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] addr_q;
	logic             cmp_vld_s1;
	logic [ID_W-1:0]  rd_id_s1;
	logic [VEC_W-1:0] rd_vec_s1;
	result_t          result_q;
	logic             done_q;

	logic issue;
	logic full;

	assign issue = cmd.scan && (addr_q < count_q);
	assign full  = (count_q == CNT_W'(ROWS));

	assign status.hit       = cmp_vld_s1 && (rd_vec_s1 == vec_q);
	assign status.exhausted = !cmp_vld_s1 && (addr_q >= count_q);

	// table write on a miss with room left; read data registered
	always_ff @(posedge clk) begin
		if (cmd.commit_miss && !full) begin
			mem[count_q[IDX_W-1:0]] <= {id_q, vec_q};
		end
		if (issue) begin
			{rd_id_s1, rd_vec_s1} <= mem[addr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q  <= item.row_id;
			vec_q <= item.row_bits & COL_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			addr_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.commit_hit || cmd.commit_miss;
			if (cmd.load) begin
				addr_q     <= '0;
				cmp_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				cmp_vld_s1 <= issue;
				if (issue) begin
					addr_q <= addr_q + 1'b1;
				end
			end else begin
				cmp_vld_s1 <= 1'b0;
			end
			if (cmd.commit_miss && !full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_hit) begin
			result_q.class_rep      <= rd_id_s1;
			result_q.is_new         <= 1'b0;
			result_q.distinct_total <= TOTAL_W'(count_q);
		end else if (cmd.commit_miss) begin
			result_q.class_rep <= id_q;
			result_q.is_new    <= !full;
			if (full) begin
				result_q.distinct_total <= TOTAL_W'(count_q);
			end else begin
				result_q.distinct_total <= TOTAL_W'(count_q + 1'b1);
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ROWS))
		else $error("fill count above table size");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_miss_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit_miss && !full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fill count did not advance on insert");

	a_cmp_issued: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (addr_q != '0 && addr_q <= count_q))
		else $error("compare without an issued read");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for bit_row_dedup_classifier.
// Holds its own dedup table predictor and checks every result in order; needs brdc_pkg
// and the RTL only.
module testbench;
	import brdc_pkg::*;

	localparam int STALL_LIMIT      = 4000;
	localparam int DRAIN_CYCLES     = 150;
	localparam int RANDOM_PER_PHASE = 577;
	localparam int N_PROBES         = 20;

	typedef struct packed {
		item_t   stim;
		logic    typed;
		result_t want;
	} probe_t;

	// typed rows are read straight off the table contents; the rest use the predictor
	probe_t probes [N_PROBES] = '{
		'{'{7'd5,   64'h0000_0000_0000_0000}, 1'b1, '{7'd5,   1'b1, 8'd1}},
		'{'{7'd127, 64'hffff_ffff_ffff_ffff}, 1'b1, '{7'd127, 1'b1, 8'd2}},
		'{'{7'd0,   64'h0000_0000_0000_0000}, 1'b1, '{7'd5,   1'b0, 8'd2}},
		'{'{7'd1,   64'hffff_ffff_ffff_ffff}, 1'b1, '{7'd127, 1'b0, 8'd2}},
		'{'{7'd5,   64'h8000_0000_0000_0000}, 1'b1, '{7'd5,   1'b1, 8'd3}},
		'{'{7'd0,   64'h0000_0000_0000_0001}, 1'b1, '{7'd0,   1'b1, 8'd4}},
		'{'{7'd127, 64'h0000_0000_0000_0001}, 1'b1, '{7'd0,   1'b0, 8'd4}},
		'{'{7'd3,   64'h7fff_ffff_ffff_ffff}, 1'b1, '{7'd3,   1'b1, 8'd5}},
		'{'{7'd4,   64'hffff_ffff_ffff_fffe}, 1'b1, '{7'd4,   1'b1, 8'd6}},
		'{'{7'd9,   64'h8000_0000_0000_0000}, 1'b1, '{7'd5,   1'b0, 8'd6}},
		'{'{7'd10,  64'haaaa_aaaa_aaaa_aaaa}, 1'b0, '0},
		'{'{7'd11,  64'h5555_5555_5555_5555}, 1'b0, '0},
		'{'{7'd12,  64'haaaa_aaaa_aaaa_aaaa}, 1'b0, '0},
		'{'{7'd13,  64'h0000_0000_0000_0000}, 1'b1, '{7'd5,   1'b0, 8'd8}},
		'{'{7'd42,  64'hdead_beef_0123_4567}, 1'b0, '0},
		'{'{7'd43,  64'h0123_4567_89ab_cdef}, 1'b0, '0},
		'{'{7'd44,  64'hdead_beef_0123_4567}, 1'b0, '0},
		'{'{7'd127, 64'hffff_ffff_ffff_ffff}, 1'b1, '{7'd127, 1'b0, 8'd10}},
		'{'{7'd0,   64'h0000_0001_0000_0000}, 1'b0, '0},
		'{'{7'd85,  64'h0000_0000_0000_0001}, 1'b1, '{7'd0,   1'b0, 8'd11}}
	};

	// sender idle percentage per random phase
	int idle_plan [3] = '{0, 72, 22};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;

	// predictor state
	logic [VEC_W-1:0] row_store [ROWS];
	logic [ID_W-1:0]  id_store  [ROWS];
	int               row_total;

	result_t pending [$];
	int      errors;
	int      results_checked;
	int      fresh_rows;
	int      matched_rows;
	int      refused_rows;
	int      stall_cycles;

	bit_row_dedup_classifier dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #2 clk = ~clk;

	// first matching stored row wins; a miss appends unless the table is full
	function automatic result_t classify(item_t it);
		result_t          r;
		logic [VEC_W-1:0] vec;
		bit               found;
		int               k;
		vec         = it.row_bits & COL_MASK;
		r.class_rep = it.row_id;
		r.is_new    = 1'b0;
		found       = 1'b0;
		for (k = 0; k < row_total && !found; k++) begin
			if (row_store[k] == vec) begin
				r.class_rep = id_store[k];
				found       = 1'b1;
			end
		end
		if (found) begin
			matched_rows++;
		end else if (row_total < ROWS) begin
			row_store[row_total] = vec;
			id_store[row_total]  = it.row_id;
			row_total++;
			r.is_new = 1'b1;
			fresh_rows++;
		end else begin
			refused_rows++;
		end
		r.distinct_total = TOTAL_W'(row_total);
		return r;
	endfunction

	// mostly repeats of stored rows, the rest sparse or fully random vectors
	function automatic item_t draw_row();
		item_t       it;
		int unsigned pick;
		it.row_id = ID_W'($urandom_range(127));
		pick      = $urandom_range(99);
		if (row_total > 0 && pick < 15)
			it.row_bits = row_store[row_total - 1];
		else if (row_total > 0 && pick < 60)
			it.row_bits = row_store[$urandom_range(row_total - 1)];
		else if (pick < 70)
			it.row_bits = 64'h1 << $urandom_range(VEC_W - 1);
		else
			it.row_bits = {$urandom, $urandom};
		return it;
	endfunction

	// returns at the edge where the transfer happens
	task automatic send_row(item_t it, int idle_pct);
		item_t noise;
		while ($urandom_range(99) < idle_pct) begin
			noise.row_id   = ID_W'($urandom);
			noise.row_bits = {$urandom, $urandom};
			start <= 1'b0;
			item  <= noise;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		result_t want;
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: class_rep %0d is_new %0d distinct_total %0d",
					$time, result.class_rep, result.is_new, result.distinct_total);
			end else begin
				want = pending.pop_front();
				results_checked++;
				if (result.class_rep !== want.class_rep) begin
					errors++;
					$display("%0t: class_rep expected %0d got %0d",
						$time, want.class_rep, result.class_rep);
				end
				if (result.is_new !== want.is_new) begin
					errors++;
					$display("%0t: is_new expected %0d got %0d",
						$time, want.is_new, result.is_new);
				end
				if (result.distinct_total !== want.distinct_total) begin
					errors++;
					$display("%0t: distinct_total expected %0d got %0d",
						$time, want.distinct_total, result.distinct_total);
				end
			end
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		item_t   it;
		result_t want;
		start  = 1'b0;
		item   = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			send_row(probes[i].stim, 0);
			want = classify(probes[i].stim);
			if (probes[i].typed)
				want = probes[i].want;
			pending = {pending, want};
		end
		drain();

		// table fills early on; later phases mix hits, deep hits and refused misses
		foreach (idle_plan[p]) begin
			repeat (RANDOM_PER_PHASE) begin
				it = draw_row();
				send_row(it, idle_plan[p]);
				want    = classify(it);
				pending = {pending, want};
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb: %0d results checked over %0d idle phases, %0d mismatches",
			results_checked, $size(idle_plan) + 1, errors);
		$display("tb: %0d rows stored, %0d matched, %0d refused with the table full",
			fresh_rows, matched_rows, refused_rows);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/brdc_pkg.sv
hw/rtl/brdc_ctrl.sv
hw/rtl/brdc_datapath.sv
hw/rtl/bit_row_dedup_classifier.sv
tb/sv/testbench.sv
